@@ rtl/core/fqs_pkg.sv @@
// Shared types, sizes and codes for the FIFO queue with search.
package fqs_pkg;

  // Queue geometry.
  localparam int DEPTH      = 16;
  localparam int ITEM_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Operation codes.
  localparam logic [1:0] OP_ENQ    = 2'd0;
  localparam logic [1:0] OP_DEQ    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_SEARCH = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // One input item.
  typedef struct packed {
    logic [1:0]                   op;
    logic signed [ITEM_WIDTH-1:0] value;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [1:0]                   status;
    logic                         found;
    logic signed [ITEM_WIDTH-1:0] front_item;
    logic signed [ITEM_WIDTH-1:0] rear_item;
    logic [CNT_W-1:0]             count;
    logic                         empty_res;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;      // capture the incoming item
    logic exec;       // perform enqueue, dequeue or clear
    logic front_load; // capture the new front after a dequeue
    logic scan_clear; // start a search from the head
    logic scan_rd;    // read the entry under the scan index
    logic scan_next;  // advance the scan index
    logic hit;        // record a search match
    logic resp;       // present the result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       is_empty;
    logic       deq_keeps_items; // a dequeue leaves at least one item
    logic       scan_last;
    logic       match;
  } dp_stat_t;

  // Ring position: base plus offset, wrapped at the depth.
  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] offset);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (IDX_W + 1)'(DEPTH)) begin
      sum = sum - (IDX_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

@@ rtl/core/fqs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH)-1:0]       waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic                           re,
  input  logic [$clog2(DEPTH)-1:0]       raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/fqs_ctrl.sv @@
// Controller state machine that sequences each queue operation.
module fqs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  fqs_pkg::dp_stat_t    stat,
  output fqs_pkg::ctrl_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_FRONT = 3'd2;
  localparam logic [2:0] S_SRD   = 3'd3;
  localparam logic [2:0] S_SCMP  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.op == fqs_pkg::OP_SEARCH) begin
          cmd.scan_clear = 1'b1;
          state_next     = stat.is_empty ? S_RESP : S_SRD;
        end else begin
          cmd.exec = 1'b1;
          if (stat.op == fqs_pkg::OP_DEQ && stat.deq_keeps_items) begin
            state_next = S_FRONT;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_FRONT: begin
        cmd.front_load = 1'b1;
        state_next     = S_RESP;
      end
      S_SRD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SCMP;
      end
      S_SCMP: begin
        if (stat.match) begin
          cmd.hit    = 1'b1;
          state_next = S_RESP;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = stat.scan_last ? S_RESP : S_SRD;
        end
      end
      S_RESP: begin
        cmd.resp   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/fqs_datapath.sv @@
// Queue datapath: ring storage, head and count, front and rear copies, search scan.
module fqs_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  fqs_pkg::cmd_t        cmd_in,
  input  fqs_pkg::ctrl_cmd_t   cmd,
  output fqs_pkg::dp_stat_t    stat,
  output fqs_pkg::res_t        result
);

  logic [1:0]                            op_q;
  logic [fqs_pkg::ITEM_WIDTH-1:0]        value_q;
  logic [fqs_pkg::IDX_W-1:0]             head;
  logic [fqs_pkg::CNT_W-1:0]             occ;
  logic [fqs_pkg::CNT_W-1:0]             idx;
  logic [fqs_pkg::ITEM_WIDTH-1:0]        front_q;
  logic [fqs_pkg::ITEM_WIDTH-1:0]        rear_q;
  logic [1:0]                            status_q;
  logic                                  found_q;

  logic                                  is_empty;
  logic                                  is_full;
  logic [fqs_pkg::IDX_W-1:0]             tail_pos;
  logic [fqs_pkg::IDX_W-1:0]             next_head;
  logic [fqs_pkg::IDX_W-1:0]             scan_pos;
  logic                                  ram_we;
  logic                                  ram_re;
  logic [fqs_pkg::IDX_W-1:0]             ram_raddr;
  logic [fqs_pkg::ITEM_WIDTH-1:0]        ram_rdata;
  logic [fqs_pkg::CNT_W-1:0]             idx_inc;

  assign is_empty  = (occ == '0);
  assign is_full   = (occ == fqs_pkg::CNT_W'(fqs_pkg::DEPTH));
  assign tail_pos  = fqs_pkg::ring_pos(head, occ[fqs_pkg::IDX_W-1:0]);
  assign next_head = fqs_pkg::ring_pos(head, fqs_pkg::IDX_W'(1));
  assign scan_pos  = fqs_pkg::ring_pos(head, idx[fqs_pkg::IDX_W-1:0]);
  assign idx_inc   = idx + fqs_pkg::CNT_W'(1);

  // Memory access: enqueue writes at the tail, dequeue reads the new front,
  // the scan reads one entry per step.
  assign ram_we    = cmd.exec && (op_q == fqs_pkg::OP_ENQ) && !is_full;
  assign ram_re    = cmd.scan_rd || (cmd.exec && (op_q == fqs_pkg::OP_DEQ));
  assign ram_raddr = cmd.scan_rd ? scan_pos : next_head;

  fqs_ram #(
    .WIDTH (fqs_pkg::ITEM_WIDTH),
    .DEPTH (fqs_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_pos),
    .wdata (value_q),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Item capture, payload copies of the ends of the queue, and the scan index.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= cmd_in.op;
      value_q <= cmd_in.value;
    end
    if (ram_we) begin
      rear_q <= value_q;
      if (is_empty) begin
        front_q <= value_q;
      end
    end
    if (cmd.front_load) begin
      front_q <= ram_rdata;
    end
    if (cmd.scan_clear) begin
      idx <= '0;
    end else if (cmd.scan_next) begin
      idx <= idx_inc;
    end
  end

  // Queue pointers, status and search flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      occ      <= '0;
      status_q <= fqs_pkg::ST_OK;
      found_q  <= 1'b0;
    end else begin
      if (cmd.latch) begin
        status_q <= fqs_pkg::ST_OK;
        found_q  <= 1'b0;
      end
      if (cmd.hit) begin
        found_q <= 1'b1;
      end
      if (cmd.exec) begin
        case (op_q)
          fqs_pkg::OP_ENQ: begin
            if (is_full) begin
              status_q <= fqs_pkg::ST_FULL;
            end else begin
              occ <= occ + fqs_pkg::CNT_W'(1);
            end
          end
          fqs_pkg::OP_DEQ: begin
            if (is_empty) begin
              status_q <= fqs_pkg::ST_EMPTY;
            end else begin
              head <= next_head;
              occ  <= occ - fqs_pkg::CNT_W'(1);
            end
          end
          fqs_pkg::OP_CLEAR: begin
            head <= '0;
            occ  <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.op              = op_q;
    stat.is_empty        = is_empty;
    stat.deq_keeps_items = (occ > fqs_pkg::CNT_W'(1));
    stat.scan_last       = (idx_inc == occ);
    stat.match           = (ram_rdata == value_q);
  end

  // Result item, taken from the registered state.
  always_comb begin
    result.status     = status_q;
    result.found      = found_q;
    result.front_item = is_empty ? '0 : front_q;
    result.rear_item  = is_empty ? '0 : rear_q;
    result.count      = occ;
    result.empty_res  = is_empty;
  end

endmodule

@@ rtl/core/fifo_queue_with_search_unit.sv @@
// Top level of the FIFO queue with associative search.
//
// Usage: an item (op, value) on cmd is accepted at a rising edge where start
// is high and busy is low. Each item gives exactly one result on the result
// port, held for one cycle and marked by done; the receiver cannot stall it.
// Operations: enqueue, dequeue, clear all, search for a value among the
// items held. Storage is a ring of DEPTH entries in one RAM with a
// registered read port, with a head index and an item count.
// Items are handled one at a time (busy is high meanwhile). Enqueue, clear
// and a dequeue that empties or fails go from accept to execute to done; a
// dequeue that leaves items adds the RAM read of the new front; a search
// reads and then compares one entry at a time, k entries examined (none on
// an empty queue, else 1..count), and stops at the first match.
// The next item may be accepted in the cycle after done.
// Reset (rst, synchronous, active high) empties the queue and returns the
// controller to idle; the RAM contents are left as they are, no clearing
// pass is needed since only the data of occupied entries is ever used.
module fifo_queue_with_search_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  fqs_pkg::cmd_t   cmd,
  output logic            done,
  output fqs_pkg::res_t   result
);

  fqs_pkg::ctrl_cmd_t ctrl_cmd;
  fqs_pkg::dp_stat_t  dp_stat;

  fqs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (dp_stat),
    .cmd   (ctrl_cmd)
  );

  fqs_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd_in (cmd),
    .cmd    (ctrl_cmd),
    .stat   (dp_stat),
    .result (result)
  );

  assign done = ctrl_cmd.resp;

endmodule
